// File: rtl/csvjp_pkg.sv
`timescale 1ns / 1ps
// csvjp_pkg: shared types and byte codes for the csv joystick frame parser
// no dependencies

package csvjp_pkg;

  typedef enum logic [1:0] {
    PhSpace,
    PhSign,
    PhDigits,
    PhDone
  } phase_e;

  localparam logic [7:0] ByteNewline = 8'd10;
  localparam logic [7:0] ByteComma   = 8'd44;
  localparam logic [7:0] ByteMinus   = 8'd45;
  localparam logic [7:0] BytePlus    = 8'd43;
  localparam logic [7:0] ByteZero    = 8'd48;
  localparam logic [7:0] ByteNine    = 8'd57;
  localparam logic [7:0] ByteTab     = 8'd9;
  localparam logic [7:0] ByteCr      = 8'd13;
  localparam logic [7:0] ByteSpace   = 8'd32;

  localparam logic [3:0]  MaxFields = 4'd12;
  localparam logic [3:0]  MinFields = 4'd7;
  localparam logic [3:0]  KFields   = 4'd8;
  localparam logic [3:0]  FlagBase  = 4'd2;
  localparam int          NumFlags  = 6;
  localparam logic [16:0] MagLimit  = 17'd32768;
  localparam logic [15:0] PosMax    = 16'h7fff;

  typedef struct packed {
    logic signed [15:0] joy_x;
    logic signed [15:0] joy_y;
    logic               button_a;
    logic               button_b;
    logic               button_c;
    logic               button_d;
    logic               button_e;
    logic               button_k;
  } frame_t;

endpackage

// File: rtl/csv_joystick_frame_parser_core.sv
`timescale 1ns / 1ps
// csv_joystick_frame_parser_core: top level of the csv joystick frame parser
// depends on csvjp_pkg, csvjp_in_reg, csvjp_parse, csvjp_out_reg
//
//   channel | direction | handshake               | payload
//   input   | in        | in_valid_i / in_stall_o | rx_byte_i
//   output  | out       | out_valid_o / out_stall_i | joy_x_o joy_y_o button_*_o
//
// one byte per cycle while in_stall_o is low; a frame appears on out_valid_o once its newline
// has passed the input register and been parsed into the result register
// reset clears the line state; no clearing pass
// an output stall holds only a newline in the input register; other bytes keep flowing

module csv_joystick_frame_parser_core #(
  parameter int MAX_LINE = 255
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] joy_x_o,
  output logic signed [15:0] joy_y_o,
  output logic               button_a_o,
  output logic               button_b_o,
  output logic               button_c_o,
  output logic               button_d_o,
  output logic               button_e_o,
  output logic               button_k_o
);

  logic              byte_vld;
  logic [7:0]        byte_q;
  logic              consume;
  logic              out_free;
  logic              fire;
  csvjp_pkg::frame_t frame_d;
  csvjp_pkg::frame_t frame_q;

  // only a newline can need the result register
  assign consume = byte_vld && (out_free || (byte_q != csvjp_pkg::ByteNewline));

  csvjp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .consume_i  (consume),
    .byte_vld_o (byte_vld),
    .byte_o     (byte_q)
  );

  csvjp_parse #(
    .MAX_LINE (MAX_LINE)
  ) u_parse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (consume),
    .byte_i  (byte_q),
    .fire_o  (fire),
    .frame_o (frame_d)
  );

  csvjp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .frame_i     (frame_d),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .frame_o     (frame_q)
  );

  assign joy_x_o    = frame_q.joy_x;
  assign joy_y_o    = frame_q.joy_y;
  assign button_a_o = frame_q.button_a;
  assign button_b_o = frame_q.button_b;
  assign button_c_o = frame_q.button_c;
  assign button_d_o = frame_q.button_d;
  assign button_e_o = frame_q.button_e;
  assign button_k_o = frame_q.button_k;

endmodule

// File: rtl/csvjp_in_reg.sv
`timescale 1ns / 1ps
// csvjp_in_reg: input register for received bytes
// depends on nothing but the consume signal from the parser stage

module csvjp_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       consume_i,
  output logic       byte_vld_o,
  output logic [7:0] byte_o
);

  logic       vld_q, vld_d;
  logic [7:0] byte_q;
  logic       accept;

  assign in_stall_o = vld_q && !consume_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (consume_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= rx_byte_i;
    end
  end

  assign byte_vld_o = vld_q;
  assign byte_o     = byte_q;

endmodule

// File: rtl/csvjp_parse.sv
`timescale 1ns / 1ps
// csvjp_parse: per-byte field decoder, line state and frame assembly
// depends on csvjp_pkg

module csvjp_parse #(
  parameter int MAX_LINE = 255
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  logic [7:0]           byte_i,
  output logic                 fire_o,
  output csvjp_pkg::frame_t    frame_o
);

  localparam int LenW = $clog2(MAX_LINE + 1);

  logic [16:0]          accum_q, accum_d;
  logic                 neg_q, neg_d;
  csvjp_pkg::phase_e    phase_q, phase_d;
  logic                 open_q, open_d;
  logic [3:0]           count_q, count_d;
  logic [15:0]          x_q, x_d;
  logic [15:0]          y_q, y_d;
  logic [5:0]           flags_q, flags_d;
  logic [LenW-1:0]      len_q, len_d;
  logic                 ovl_q, ovl_d;

  logic                 is_nl, is_comma, is_digit, is_space;
  logic                 use_digit;
  logic [20:0]          acc_next;
  logic [16:0]          acc_neg;
  logic [15:0]          val;
  logic                 val_one;
  logic                 commit_en;
  logic [3:0]           count_c;
  logic [15:0]          x_c, y_c;
  logic [5:0]           flags_c;

  assign is_nl    = (byte_i == csvjp_pkg::ByteNewline);
  assign is_comma = (byte_i == csvjp_pkg::ByteComma);
  assign is_digit = (byte_i >= csvjp_pkg::ByteZero) && (byte_i <= csvjp_pkg::ByteNine);
  assign is_space = (byte_i == csvjp_pkg::ByteSpace) ||
                    ((byte_i >= csvjp_pkg::ByteTab) && (byte_i <= csvjp_pkg::ByteCr));

  // committed value of the open field
  assign acc_neg = 17'(-accum_q);
  always_comb begin
    if (neg_q) begin
      val = acc_neg[15:0];
    end else if (accum_q > {1'b0, csvjp_pkg::PosMax}) begin
      val = csvjp_pkg::PosMax;
    end else begin
      val = accum_q[15:0];
    end
  end
  assign val_one = !neg_q && (accum_q == 17'd1);

  assign commit_en = open_q &&
                     (is_nl ? !ovl_q : !(ovl_q || (len_q >= LenW'(MAX_LINE))));

  always_comb begin
    x_c     = x_q;
    y_c     = y_q;
    flags_c = flags_q;
    count_c = count_q;
    if (commit_en) begin
      if (count_q == 4'd0) begin
        x_c = val;
      end else if (count_q == 4'd1) begin
        y_c = val;
      end
      for (int i = 0; i < csvjp_pkg::NumFlags; i++) begin
        if (count_q == csvjp_pkg::FlagBase + 4'(i)) begin
          flags_c[i] = val_one;
        end
      end
      if (count_q < csvjp_pkg::MaxFields) begin
        count_c = count_q + 4'd1;
      end
    end
  end

  assign acc_next = ({4'd0, accum_q} << 3) + ({4'd0, accum_q} << 1) +
                    {13'd0, byte_i - csvjp_pkg::ByteZero};

  always_comb begin
    accum_d   = accum_q;
    neg_d     = neg_q;
    phase_d   = phase_q;
    open_d    = open_q;
    count_d   = count_q;
    x_d       = x_q;
    y_d       = y_q;
    flags_d   = flags_q;
    len_d     = len_q;
    ovl_d     = ovl_q;
    use_digit = 1'b0;
    fire_o    = 1'b0;

    if (!is_nl) begin
      if (len_q >= LenW'(MAX_LINE)) begin
        ovl_d = 1'b1;
      end else begin
        len_d = len_q + LenW'(1);
      end
    end

    if (is_nl) begin
      fire_o  = take_i && !ovl_q && (count_c >= csvjp_pkg::MinFields);
      accum_d = '0;
      neg_d   = 1'b0;
      phase_d = csvjp_pkg::PhSpace;
      open_d  = 1'b0;
      count_d = '0;
      x_d     = '0;
      y_d     = '0;
      flags_d = '0;
      len_d   = '0;
      ovl_d   = 1'b0;
    end else if (ovl_d) begin
      // overlong line: wait for the newline
    end else if (is_comma) begin
      count_d = count_c;
      x_d     = x_c;
      y_d     = y_c;
      flags_d = flags_c;
      accum_d = '0;
      neg_d   = 1'b0;
      phase_d = csvjp_pkg::PhSpace;
      open_d  = 1'b0;
    end else begin
      open_d = 1'b1;
      unique case (phase_q)
        csvjp_pkg::PhSpace: begin
          if (is_space) begin
            phase_d = csvjp_pkg::PhSpace;
          end else if (byte_i == csvjp_pkg::ByteMinus) begin
            neg_d   = 1'b1;
            phase_d = csvjp_pkg::PhSign;
          end else if (byte_i == csvjp_pkg::BytePlus) begin
            phase_d = csvjp_pkg::PhSign;
          end else begin
            use_digit = 1'b1;
          end
        end
        csvjp_pkg::PhSign, csvjp_pkg::PhDigits: begin
          use_digit = 1'b1;
        end
        csvjp_pkg::PhDone: begin
          phase_d = csvjp_pkg::PhDone;
        end
        default: begin
          phase_d = csvjp_pkg::PhDone;
        end
      endcase
      if (use_digit) begin
        if (is_digit) begin
          accum_d = (acc_next > {4'd0, csvjp_pkg::MagLimit}) ? csvjp_pkg::MagLimit
                                                              : acc_next[16:0];
          phase_d = csvjp_pkg::PhDigits;
        end else begin
          phase_d = csvjp_pkg::PhDone;
        end
      end
    end
  end

  always_comb begin
    frame_o.joy_x    = x_c;
    frame_o.joy_y    = y_c;
    frame_o.button_a = flags_c[0];
    frame_o.button_b = flags_c[1];
    frame_o.button_c = flags_c[2];
    frame_o.button_d = flags_c[3];
    frame_o.button_e = flags_c[4];
    frame_o.button_k = (count_c >= csvjp_pkg::KFields) ? flags_c[5] : flags_c[4];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q <= '0;
      neg_q   <= 1'b0;
      phase_q <= csvjp_pkg::PhSpace;
      open_q  <= 1'b0;
      count_q <= '0;
      x_q     <= '0;
      y_q     <= '0;
      flags_q <= '0;
      len_q   <= '0;
      ovl_q   <= 1'b0;
    end else if (take_i) begin
      accum_q <= accum_d;
      neg_q   <= neg_d;
      phase_q <= phase_d;
      open_q  <= open_d;
      count_q <= count_d;
      x_q     <= x_d;
      y_q     <= y_d;
      flags_q <= flags_d;
      len_q   <= len_d;
      ovl_q   <= ovl_d;
    end
  end

`ifndef SYNTH
  a_no_frame_overlong: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_o |-> !ovl_q)
    else $error("frame produced from overlong line");
  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= csvjp_pkg::MaxFields)
    else $error("field count beyond saturation");
  a_accum_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accum_q <= csvjp_pkg::MagLimit)
    else $error("field magnitude beyond limit");
  a_space_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == csvjp_pkg::PhSpace |-> (accum_q == 17'd0) && !neg_q)
    else $error("whitespace phase with stale field data");
  a_newline_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && is_nl |=> (count_q == 4'd0) && !open_q && !ovl_q)
    else $error("line state not cleared after newline");
`endif

endmodule

// File: rtl/csvjp_out_reg.sv
`timescale 1ns / 1ps
// csvjp_out_reg: result register holding one decoded frame
// depends on csvjp_pkg

module csvjp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  csvjp_pkg::frame_t frame_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output csvjp_pkg::frame_t frame_o
);

  logic              vld_q, vld_d;
  csvjp_pkg::frame_t frame_q;

  assign free_o = !vld_q || !out_stall_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (!out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      frame_q <= frame_i;
    end
  end

  assign out_valid_o = vld_q;
  assign frame_o     = frame_q;

endmodule

// File: tb/tb_csv_joystick_frame_parser_core.sv
`timescale 1ns / 1ps
// tb_csv_joystick_frame_parser_core: self-checking bench for the csv joystick frame parser
// depends on csvjp_pkg and csv_joystick_frame_parser_core; canned lines, then random csv traffic

module tb_csv_joystick_frame_parser_core;

  localparam int LineMax = 255;
  localparam int HoldCycles = 300;
  localparam int QuietLimit = 4000;
  localparam int DrainCycles = 8;
  localparam int RandBytes = 1000;
  localparam logic [7:0] ByteVt = 8'd11;
  localparam logic [7:0] ByteFf = 8'd12;

  typedef struct {
    string             text;
    int                pad;
    bit                typed;
    bit                fires;
    csvjp_pkg::frame_t want;
  } canned_line_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [7:0]         rx_byte_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [15:0] joy_x_o;
  logic signed [15:0] joy_y_o;
  logic               button_a_o;
  logic               button_b_o;
  logic               button_c_o;
  logic               button_d_o;
  logic               button_e_o;
  logic               button_k_o;

  csv_joystick_frame_parser_core #(
    .MAX_LINE(LineMax)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .joy_x_o    (joy_x_o),
    .joy_y_o    (joy_y_o),
    .button_a_o (button_a_o),
    .button_b_o (button_b_o),
    .button_c_o (button_c_o),
    .button_d_o (button_d_o),
    .button_e_o (button_e_o),
    .button_k_o (button_k_o)
  );

  // line parser state
  logic [16:0]       mag;
  logic              neg;
  csvjp_pkg::phase_e phase;
  logic              open_fld;
  logic [3:0]        n_fields;
  logic [15:0]       x_hold;
  logic [15:0]       y_hold;
  logic [5:0]        flag_hold;
  logic [11:0]       line_len;
  logic              line_long;

  csvjp_pkg::frame_t frames_due[$];
  logic [7:0]        line_q[$];
  canned_line_t      canned[$];
  int                mismatches = 0;
  int                bytes_sent = 0;
  int                quiet_cycles = 0;
  bit                gaps_on = 1'b1;
  bit                hold_req = 1'b0;
  bit                hold_done = 1'b0;
  bit                row_typed = 1'b0;
  bit                row_fires = 1'b0;
  csvjp_pkg::frame_t row_want;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic csvjp_pkg::frame_t frame_of(input int x, input int y,
                                                 input logic [5:0] flags);
    return csvjp_pkg::frame_t'({x[15:0], y[15:0], flags});
  endfunction

  function automatic void clear_field();
    mag = '0;
    neg = 1'b0;
    phase = csvjp_pkg::PhSpace;
    open_fld = 1'b0;
  endfunction

  function automatic void clear_line();
    clear_field();
    n_fields = '0;
    x_hold = '0;
    y_hold = '0;
    flag_hold = '0;
    line_len = '0;
    line_long = 1'b0;
  endfunction

  function automatic void close_field();
    logic [16:0] twos;
    logic [15:0] v;
    twos = -mag;
    if (neg) v = twos[15:0];
    else v = (mag > {1'b0, csvjp_pkg::PosMax}) ? csvjp_pkg::PosMax : mag[15:0];
    if (n_fields == 4'd0) x_hold = v;
    else if (n_fields == 4'd1) y_hold = v;
    else if (n_fields < csvjp_pkg::KFields)
      flag_hold[n_fields - csvjp_pkg::FlagBase] = (v == 16'd1);
    if (n_fields < csvjp_pkg::MaxFields) n_fields = n_fields + 4'd1;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, output csvjp_pkg::frame_t f);
    bit is_digit;
    bit is_space;
    bit to_digits;
    bit fired;
    int grown;
    f = '0;
    is_digit = (b >= csvjp_pkg::ByteZero) && (b <= csvjp_pkg::ByteNine);
    is_space = ((b >= csvjp_pkg::ByteTab) && (b <= csvjp_pkg::ByteCr)) ||
               (b == csvjp_pkg::ByteSpace);
    if (b == csvjp_pkg::ByteNewline) begin
      if (!line_long && open_fld) close_field();
      fired = !line_long && (n_fields >= csvjp_pkg::MinFields);
      if (fired) begin
        f = frame_of(x_hold, y_hold, {flag_hold[0], flag_hold[1], flag_hold[2],
                     flag_hold[3], flag_hold[4],
                     (n_fields >= csvjp_pkg::KFields) ? flag_hold[5] : flag_hold[4]});
      end
      clear_line();
      return fired;
    end
    if (line_len >= LineMax) line_long = 1'b1;
    else line_len = line_len + 12'd1;
    if (line_long) return 1'b0;
    if (b == csvjp_pkg::ByteComma) begin
      if (open_fld) close_field();
      clear_field();
      return 1'b0;
    end
    open_fld = 1'b1;
    to_digits = (phase == csvjp_pkg::PhSign) || (phase == csvjp_pkg::PhDigits) ||
                ((phase == csvjp_pkg::PhSpace) && !is_space &&
                 (b != csvjp_pkg::ByteMinus) && (b != csvjp_pkg::BytePlus));
    if ((phase == csvjp_pkg::PhSpace) && (b == csvjp_pkg::ByteMinus)) begin
      neg = 1'b1;
      phase = csvjp_pkg::PhSign;
    end else if ((phase == csvjp_pkg::PhSpace) && (b == csvjp_pkg::BytePlus)) begin
      phase = csvjp_pkg::PhSign;
    end else if (to_digits) begin
      if (is_digit) begin
        grown = int'(mag) * 10 + int'(b - csvjp_pkg::ByteZero);
        mag = (grown > int'(csvjp_pkg::MagLimit)) ? csvjp_pkg::MagLimit : grown[16:0];
        phase = csvjp_pkg::PhDigits;
      end else begin
        phase = csvjp_pkg::PhDone;
      end
    end
    return 1'b0;
  endfunction

  task automatic note_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
  endtask

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] rand_space();
    case ($urandom_range(4))
      0: return csvjp_pkg::ByteTab;
      1: return ByteVt;
      2: return ByteFf;
      3: return csvjp_pkg::ByteCr;
      default: return csvjp_pkg::ByteSpace;
    endcase
  endfunction

  function automatic logic [7:0] rand_junk();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == csvjp_pkg::ByteNewline || b == csvjp_pkg::ByteComma);
    return b;
  endfunction

  function automatic void push_field();
    if ($urandom_range(4) == 0) line_q.push_back(rand_space());
    case ($urandom_range(11))
      0, 1, 2, 3: push_text("1");
      4: push_text("0");
      5: push_text($sformatf("%0d", $urandom_range(20)));
      6: push_text($sformatf("%0d", int'($urandom_range(80000)) - 40000));
      7: push_text($sformatf("%0d", int'($urandom)));
      8: begin
        push_text($urandom_range(1) ? "+" : "-");
        if ($urandom_range(1)) push_text($sformatf("%0d", $urandom_range(2)));
      end
      9: push_text($sformatf("%05d", $urandom_range(2)));
      10: ;
      default: line_q.push_back(rand_junk());
    endcase
    if ($urandom_range(99) < 15) line_q.push_back(rand_junk());
  endfunction

  // mostly well-formed lines, some short, long, overlong or pure noise
  function automatic void build_line();
    int kind;
    int nf;
    kind = $urandom_range(99);
    line_q.delete();
    if (kind < 6) begin
      repeat ($urandom_range(30, 1)) line_q.push_back(8'($urandom_range(255)));
      return;
    end
    if (kind < 9) begin
      repeat ($urandom_range(270, 235))
        line_q.push_back($urandom_range(3) ? rand_space() : rand_junk());
    end
    if (kind < 22) nf = $urandom_range(6, 3);
    else if (kind < 35) nf = $urandom_range(14, 10);
    else nf = $urandom_range(9, 7);
    if ($urandom_range(9) == 0) line_q.push_back(csvjp_pkg::ByteComma);
    for (int i = 0; i < nf; i++) begin
      push_field();
      if (i < nf - 1) line_q.push_back(csvjp_pkg::ByteComma);
    end
    if ($urandom_range(9) == 0) line_q.push_back(csvjp_pkg::ByteComma);
    line_q.push_back(csvjp_pkg::ByteNewline);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    csvjp_pkg::frame_t f;
    bit                fired;
    while (gaps_on && ($urandom_range(99) < 20)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    bytes_sent++;
    fired = parse_byte(b, f);
    if (b == csvjp_pkg::ByteNewline && row_typed) begin
      if (row_fires) frames_due.push_back(row_want);
    end else if (fired) begin
      frames_due.push_back(f);
    end
  endtask

  task automatic send_queued();
    foreach (line_q[i]) send_byte(line_q[i]);
  endtask

  // receiver: random stalls, plus one long hold counted here
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end
      out_stall_i <= gaps_on && ($urandom_range(99) < 20);
    end
  end

  always @(posedge clk_i) begin : frame_check
    csvjp_pkg::frame_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frames_due.size() == 0) begin
        note_mismatch("frame with none pending, joy_x", joy_x_o, 0);
      end else begin
        want = frames_due.pop_front();
        if (joy_x_o !== want.joy_x) note_mismatch("joy_x", joy_x_o, want.joy_x);
        if (joy_y_o !== want.joy_y) note_mismatch("joy_y", joy_y_o, want.joy_y);
        if (button_a_o !== want.button_a) note_mismatch("button_a", button_a_o, want.button_a);
        if (button_b_o !== want.button_b) note_mismatch("button_b", button_b_o, want.button_b);
        if (button_c_o !== want.button_c) note_mismatch("button_c", button_c_o, want.button_c);
        if (button_d_o !== want.button_d) note_mismatch("button_d", button_d_o, want.button_d);
        if (button_e_o !== want.button_e) note_mismatch("button_e", button_e_o, want.button_e);
        if (button_k_o !== want.button_k) note_mismatch("button_k", button_k_o, want.button_k);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("tb_csv_joystick_frame_parser_core NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int  base;
    bit  paused;
    paused = 1'b0;
    clear_line();
    canned.push_back(canned_line_t'{"1,2,1,1,1,1,1", 0, 1'b1, 1'b1,
                                    frame_of(1, 2, 6'b111111)});
    canned.push_back(canned_line_t'{"32767,-32768,0,0,0,0,0,0", 0, 1'b1, 1'b1,
                                    frame_of(32767, -32768, 6'b000000)});
    canned.push_back(canned_line_t'{"99999,-99999,1,0,1,0,1,0", 0, 1'b1, 1'b1,
                                    frame_of(32767, -32768, 6'b101010)});
    canned.push_back(canned_line_t'{"1,2,3,4,5,6", 0, 1'b1, 1'b0, '0});
    canned.push_back(canned_line_t'{"1,1,1,1,1,1,1,1,1,1,1,1,1,0", 0, 1'b1, 1'b1,
                                    frame_of(1, 1, 6'b111111)});
    canned.push_back(canned_line_t'{"-0,+0,1,1,1,1,0", 0, 1'b1, 1'b1,
                                    frame_of(0, 0, 6'b111100)});
    canned.push_back(canned_line_t'{"5,6,1,1,1,1,1,0", 0, 1'b1, 1'b1,
                                    frame_of(5, 6, 6'b111110)});
    canned.push_back(canned_line_t'{"1,2,1,1,1,1,1", 242, 1'b1, 1'b1,
                                    frame_of(1, 2, 6'b111111)});
    canned.push_back(canned_line_t'{"1,2,1,1,1,1,1", 243, 1'b1, 1'b0, '0});
    canned.push_back(canned_line_t'{"7,8,1,1,1,1,1", 0, 1'b0, 1'b0, '0});
    canned.push_back(canned_line_t'{"", 0, 1'b1, 1'b0, '0});
    canned.push_back(canned_line_t'{",,  -7 ,+12x,,-1,\t1,+,-,1abc,,1,0,0,5,", 0, 1'b0,
                                    1'b0, '0});
    canned.push_back(canned_line_t'{"00001,-00001,01,1x, +1,1 1,1,-1", 0, 1'b0, 1'b0, '0});
    canned.push_back(canned_line_t'{"7,8,1,1,1,1, 1 ", 0, 1'b0, 1'b0, '0});
    canned.push_back(canned_line_t'{"65536,-32769,1,1,1,1,1,1,1,1,1,1,1", 0, 1'b0, 1'b0,
                                    '0});

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (canned[i]) begin
      line_q.delete();
      repeat (canned[i].pad) line_q.push_back(csvjp_pkg::ByteSpace);
      push_text(canned[i].text);
      line_q.push_back(csvjp_pkg::ByteNewline);
      row_typed = canned[i].typed;
      row_fires = canned[i].fires;
      row_want = canned[i].want;
      send_queued();
    end
    row_typed = 1'b0;

    base = bytes_sent;
    while (bytes_sent < base + RandBytes) begin
      gaps_on = !((bytes_sent >= base + 250) && (bytes_sent < base + 450));
      if ((bytes_sent >= base + 500) && !hold_req) begin
        hold_req = 1'b1;
        while (!hold_done) begin
          build_line();
          send_queued();
        end
      end
      if ((bytes_sent >= base + 850) && !paused) begin
        paused = 1'b1;
        in_valid_i <= 1'b0;
        while (frames_due.size() != 0) @(posedge clk_i);
      end
      build_line();
      send_queued();
    end
    in_valid_i <= 1'b0;

    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_csv_joystick_frame_parser_core OK");
    end else begin
      $display("tb_csv_joystick_frame_parser_core NOT OK");
    end
    $finish;
  end

endmodule
